>>> rtl/sca_pkg.sv
package sca_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // status codes of a result word
    localparam logic [1:0] ST_ENTRY    = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // register indexes of the configuration port
    localparam logic [1:0] REG_A_ROWS = 2'd0;
    localparam logic [1:0] REG_A_COLS = 2'd1;
    localparam logic [1:0] REG_B_ROWS = 2'd2;
    localparam logic [1:0] REG_B_COLS = 2'd3;

    // matrix dimensions held in the configuration registers
    typedef struct packed {
        logic [15:0] a_rows;
        logic [15:0] a_cols;
        logic [15:0] b_rows;
        logic [15:0] b_cols;
    } cfg_t;

endpackage

>>> rtl/sca_store.sv
module sca_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sca_merge.sv
module sca_merge #(
    parameter int MAX_ENTRIES = 32,
    parameter int INDEX_BITS  = 16,
    parameter int AW          = 5,
    parameter int CW          = 6,
    parameter int DW          = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sca_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [15:0]         row,
    input  logic [15:0]         col,
    input  logic signed [31:0]  value,
    output logic                a_we,
    output logic [AW-1:0]       a_waddr,
    output logic                b_we,
    output logic [AW-1:0]       b_waddr,
    output logic [DW-1:0]       wdata,
    output logic [AW-1:0]       a_raddr,
    output logic [AW-1:0]       b_raddr,
    input  logic [DW-1:0]       a_rdata,
    input  logic [DW-1:0]       b_rdata,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         out_row,
    output logic [15:0]         out_col,
    output logic signed [31:0]  out_value,
    output logic [1:0]          status,
    output logic                last
);
    import sca_pkg::*;

    localparam int PW = 2 * INDEX_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     a_cnt_reg, a_cnt_next;
    logic [CW-1:0]     b_cnt_reg, b_cnt_next;
    logic [CW-1:0]     a_idx_reg, a_idx_next;
    logic [CW-1:0]     b_idx_reg, b_idx_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       out_row_reg, out_row_next;
    logic [15:0]       out_col_reg, out_col_next;
    logic [31:0]       out_value_reg, out_value_next;
    logic [1:0]        status_reg, status_next;
    logic              last_reg, last_next;

    logic              slot_free;
    logic              a_has, b_has, take_a, take_b, same_pos;
    logic [PW-1:0]     a_pos, b_pos;
    logic [31:0]       a_val, b_val;
    logic [CW-1:0]     a_idx_adv, b_idx_adv;
    logic [CW-1:0]     max_cnt;

    assign max_cnt = CW'(MAX_ENTRIES);

    // fields of the two words under the read pointers
    assign a_pos = a_rdata[DW-1 -: PW];
    assign b_pos = b_rdata[DW-1 -: PW];
    assign a_val = a_rdata[31:0];
    assign b_val = b_rdata[31:0];

    // merge decision: smaller position goes first, equal positions are summed
    assign a_has    = a_idx_reg < a_cnt_reg;
    assign b_has    = b_idx_reg < b_cnt_reg;
    assign same_pos = a_has && b_has && (a_pos == b_pos);
    assign take_a   = a_has && (!b_has || (a_pos < b_pos) || same_pos);
    assign take_b   = b_has && (!a_has || (a_pos > b_pos) || same_pos);
    assign a_idx_adv = take_a ? a_idx_reg + 1'b1 : a_idx_reg;
    assign b_idx_adv = take_b ? b_idx_reg + 1'b1 : b_idx_reg;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    // load word packing and store write ports
    assign wdata   = {row[INDEX_BITS-1:0], col[INDEX_BITS-1:0], 32'(value)};
    assign a_waddr = a_cnt_reg[AW-1:0];
    assign b_waddr = b_cnt_reg[AW-1:0];

    // read pointers take the next index so read data lines up with the index
    assign a_raddr = a_idx_next[AW-1:0];
    assign b_raddr = b_idx_next[AW-1:0];

    // control sequencer
    always_comb
    begin
        state_next     = state_reg;
        a_cnt_next     = a_cnt_reg;
        b_cnt_next     = b_cnt_reg;
        a_idx_next     = a_idx_reg;
        b_idx_next     = b_idx_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                a_idx_next = '0;
                b_idx_next = '0;
                if (in_valid)
                begin
                    case (operation)
                        OP_LOAD_A:
                        begin
                            if (a_cnt_reg < max_cnt)
                            begin
                                a_we       = 1'b1;
                                a_cnt_next = a_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_LOAD_B:
                        begin
                            if (b_cnt_reg < max_cnt)
                            begin
                                b_we       = 1'b1;
                                b_cnt_next = b_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_START:
                        begin
                            state_next = S_START;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_START:
            begin
                a_idx_next = '0;
                b_idx_next = '0;
                if (slot_free)
                begin
                    if ((cfg.a_rows != cfg.b_rows) || (cfg.a_cols != cfg.b_cols) || ovf_reg
                        || ((a_cnt_reg == '0) && (b_cnt_reg == '0)))
                    begin
                        out_valid_next = 1'b1;
                        out_row_next   = '0;
                        out_col_next   = '0;
                        out_value_next = '0;
                        last_next      = 1'b1;
                        if ((cfg.a_rows != cfg.b_rows) || (cfg.a_cols != cfg.b_cols))
                        begin
                            status_next = ST_MISMATCH;
                        end
                        else if (ovf_reg)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                        end
                        a_cnt_next = '0;
                        b_cnt_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_ENTRY;
                    if (take_a)
                    begin
                        out_row_next = 16'(a_pos[PW-1 -: INDEX_BITS]);
                        out_col_next = 16'(a_pos[INDEX_BITS-1:0]);
                    end
                    else
                    begin
                        out_row_next = 16'(b_pos[PW-1 -: INDEX_BITS]);
                        out_col_next = 16'(b_pos[INDEX_BITS-1:0]);
                    end
                    if (same_pos)
                    begin
                        out_value_next = a_val + b_val;
                    end
                    else if (take_a)
                    begin
                        out_value_next = a_val;
                    end
                    else
                    begin
                        out_value_next = b_val;
                    end
                    a_idx_next = a_idx_adv;
                    b_idx_next = b_idx_adv;
                    last_next  = (a_idx_adv >= a_cnt_reg) && (b_idx_adv >= b_cnt_reg);
                    if (last_next)
                    begin
                        a_cnt_next = '0;
                        b_cnt_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            a_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            a_idx_reg     <= '0;
            b_idx_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_cnt_reg     <= a_cnt_next;
            b_cnt_reg     <= b_cnt_next;
            a_idx_reg     <= a_idx_next;
            b_idx_reg     <= b_idx_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = signed'(out_value_reg);
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

>>> rtl/sparse_coo_matrix_add.sv
// Sparse matrix adder in coordinate form. Input words with operation 0 or 1 append a
// (row, col, value) entry to store A or B, one word per cycle while idle; entries beyond
// MAX_ENTRIES are dropped and flagged. A start word (operation 2) checks the
// dimensions in the APB registers, then the stored overflow flag, then for two empty
// stores, each giving a single status word; otherwise it walks both stores in step,
// merging by (row, col) and summing equal positions with 32-bit wrap. Both stores
// are simple dual-port synchronous RAMs read at the next index value, so the merge
// emits one result word per cycle while out_ready stays high; a start first passes
// a check state before the merge. The final word of each start carries last, and
// both stores and the overflow flag are then empty again. New words are taken only
// while no start is in progress; loads are still taken while a result word waits.
module sparse_coo_matrix_add #(
    parameter int MAX_ENTRIES = 32,
    parameter int INDEX_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [15:0]        row,
    input  logic [15:0]        col,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        out_row,
    output logic [15:0]        out_col,
    output logic signed [31:0] out_value,
    output logic [1:0]         status,
    output logic               last
);
    import sca_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int DW = 2 * INDEX_BITS + 32;

    cfg_t          cfg_reg;
    logic          a_we, b_we;
    logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
    logic [DW-1:0] wdata, a_rdata, b_rdata;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_A_ROWS: cfg_reg.a_rows <= pwdata[15:0];
                REG_A_COLS: cfg_reg.a_cols <= pwdata[15:0];
                REG_B_ROWS: cfg_reg.b_rows <= pwdata[15:0];
                REG_B_COLS: cfg_reg.b_cols <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // configuration register reads
    always_comb
    begin
        case (paddr[3:2])
            REG_A_ROWS: prdata = 32'(cfg_reg.a_rows);
            REG_A_COLS: prdata = 32'(cfg_reg.a_cols);
            REG_B_ROWS: prdata = 32'(cfg_reg.b_rows);
            REG_B_COLS: prdata = 32'(cfg_reg.b_cols);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    sca_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW),
        .DW    (DW)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    sca_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW),
        .DW    (DW)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    sca_merge #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .INDEX_BITS  (INDEX_BITS),
        .AW          (AW),
        .CW          (CW),
        .DW          (DW)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .row       (row),
        .col       (col),
        .value     (value),
        .a_we      (a_we),
        .a_waddr   (a_waddr),
        .b_we      (b_we),
        .b_waddr   (b_waddr),
        .wdata     (wdata),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr),
        .a_rdata   (a_rdata),
        .b_rdata   (b_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .status    (status),
        .last      (last)
    );

endmodule
